// ===== hw/rtl/cdhw_pkg.sv =====
// Package for the consumer data hold watchdog.
// Holds the field widths, mode codes and reset defaults. No dependencies.
`timescale 1ns / 1ps

package cdhw_pkg;

  localparam int MODE_W   = 2;
  localparam int FRAMES_W = 16;
  localparam int STATUS_W = 8;
  localparam int HOLD_W   = 16;
  localparam int TOTAL_W  = 32;
  localparam int BIT_IDX_W = $clog2(STATUS_W);

  localparam int PROVIDER_BIT_DEF = 4;
  localparam int PROBLEM_BIT_DEF  = 5;

  localparam logic [HOLD_W-1:0] HOLD_FACTOR_RST = HOLD_W'(3);
  localparam logic [HOLD_W-1:0] HOLD_MAX        = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2
  } mode_t;

endpackage

// ===== hw/rtl/consumer_data_hold_watchdog_unit.sv =====
// Consumer data hold watchdog: top level, the only module.
// Depends on cdhw_pkg for widths, mode codes and reset defaults.
`timescale 1ns / 1ps

// A request accepted into the input register has its result loaded into the
// output register, unless that register still holds a stalled result.
// Throughput: one request per cycle when out_stall does not hold the output
// register; the input register feeds the state update and output register
// directly, so consecutive ticks see updated state.
// Reset (rst_n low, synchronous): disarmed, waiting phase, status/counter/total
// cleared, hold factor back to 3, both pipeline registers empty.
module consumer_data_hold_watchdog_unit #(
  parameter int PROVIDER_BIT = cdhw_pkg::PROVIDER_BIT_DEF,
  parameter int PROBLEM_BIT  = cdhw_pkg::PROBLEM_BIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cdhw_pkg::HOLD_W-1:0]    cfg_hold_factor,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cdhw_pkg::MODE_W-1:0]    in_mode,
  input  logic [cdhw_pkg::FRAMES_W-1:0]  in_frames_received,
  input  logic [cdhw_pkg::STATUS_W-1:0]  in_status_byte,
  input  logic                           in_status_mismatch,
  input  logic                           in_stopped_event,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_armed,
  output logic                           out_phase,
  output logic [cdhw_pkg::STATUS_W-1:0]  out_changed_bits,
  output logic                           out_status_change_note,
  output logic                           out_new_data_note,
  output logic                           out_entered_run,
  output logic                           out_aborted,
  output logic [cdhw_pkg::HOLD_W-1:0]    out_hold_count,
  output logic [cdhw_pkg::TOTAL_W-1:0]   out_total_frames
);
  import cdhw_pkg::*;

  localparam logic [BIT_IDX_W-1:0] PROV_IDX = BIT_IDX_W'(PROVIDER_BIT);
  localparam logic [BIT_IDX_W-1:0] PROB_IDX = BIT_IDX_W'(PROBLEM_BIT);

  // ---------------- configuration ----------------
  logic [HOLD_W-1:0] hold_factor_r;

  // Always ready: config must only arrive while idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_factor_r <= HOLD_FACTOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      hold_factor_r <= cfg_hold_factor;
    end
  end

  // ---------------- input register ----------------
  logic                 s1_vld_r;
  mode_t                s1_mode_r;
  logic [FRAMES_W-1:0]  s1_frames_r;
  logic [STATUS_W-1:0]  s1_status_r;
  logic                 s1_mismatch_r;
  logic                 s1_stopped_r;

  logic out_valid_r;
  logic adv;        // input register moves into the output register
  logic in_acc;     // request taken this cycle
  logic s1_vld_nxt;

  // Advance when the output register is empty or being drained.
  assign adv      = s1_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign s1_vld_nxt = in_acc || (s1_vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r     <= mode_t'(in_mode);
      s1_frames_r   <= in_frames_received;
      s1_status_r   <= in_status_byte;
      s1_mismatch_r <= in_status_mismatch;
      s1_stopped_r  <= in_stopped_event;
    end
  end

  // ---------------- watchdog state ----------------
  logic                armed_r,        armed_nxt;
  logic                run_phase_r,    run_phase_nxt;
  logic [STATUS_W-1:0] last_status_r,  last_status_nxt;
  logic [HOLD_W-1:0]   hold_counter_r, hold_counter_nxt;
  logic [TOTAL_W-1:0]  frame_total_r,  frame_total_nxt;

  logic [STATUS_W-1:0] chg;
  logic                note_status;
  logic                note_data;
  logic                entered;
  logic                aborted;
  logic                has_frames;
  logic                clear_hold;
  logic                expired;

  assign has_frames = |s1_frames_r;

  // Next-state logic for the request in the input register.
  always_comb begin
    armed_nxt        = armed_r;
    run_phase_nxt    = run_phase_r;
    last_status_nxt  = last_status_r;
    hold_counter_nxt = hold_counter_r;
    frame_total_nxt  = frame_total_r;
    chg              = '0;
    note_status      = 1'b0;
    note_data        = 1'b0;
    entered          = 1'b0;
    aborted          = 1'b0;
    clear_hold       = 1'b0;
    expired          = 1'b0;

    unique case (s1_mode_r)
      MODE_START: begin
        armed_nxt = 1'b1;
      end
      MODE_STOP: begin
        armed_nxt = 1'b0;
      end
      MODE_TICK: begin
        if (armed_r) begin
          frame_total_nxt = frame_total_r + TOTAL_W'(s1_frames_r);
          chg             = last_status_r ^ s1_status_r;
          last_status_nxt = s1_status_r;

          if (!run_phase_r) begin
            // waiting: first good provider data starts the run phase
            if (has_frames && s1_status_r[PROV_IDX]) begin
              run_phase_nxt = 1'b1;
              entered       = 1'b1;
            end
          end else begin
            note_status = |chg;
            note_data   = has_frames;
          end

          // hold timer cleared while waiting, on good data, or when the
          // provider or problem indication is not asserted
          clear_hold = !run_phase_r
                    || (has_frames && !s1_mismatch_r)
                    || !s1_status_r[PROV_IDX]
                    || !s1_status_r[PROB_IDX];

          if (clear_hold) begin
            hold_counter_nxt = '0;
          end else if (hold_counter_r != HOLD_MAX) begin
            hold_counter_nxt = hold_counter_r + HOLD_W'(1);
          end

          // expiry on equality only; a lowered factor lets it saturate
          expired = (hold_counter_nxt == hold_factor_r);

          if (expired || s1_stopped_r) begin
            aborted          = 1'b1;
            hold_counter_nxt = '0;
            armed_nxt        = 1'b0;
            run_phase_nxt    = 1'b0;
          end
        end
      end
      default: begin
        // unused mode: no-op, reported like a disarmed tick
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r        <= 1'b0;
      run_phase_r    <= 1'b0;
      last_status_r  <= '0;
      hold_counter_r <= '0;
      frame_total_r  <= '0;
    end else if (adv) begin
      armed_r        <= armed_nxt;
      run_phase_r    <= run_phase_nxt;
      last_status_r  <= last_status_nxt;
      hold_counter_r <= hold_counter_nxt;
      frame_total_r  <= frame_total_nxt;
    end
  end

  // ---------------- output register ----------------
  logic                out_valid_nxt;
  logic                out_armed_r;
  logic                out_phase_r;
  logic [STATUS_W-1:0] out_changed_bits_r;
  logic                out_status_change_note_r;
  logic                out_new_data_note_r;
  logic                out_entered_run_r;
  logic                out_aborted_r;
  logic [HOLD_W-1:0]   out_hold_count_r;
  logic [TOTAL_W-1:0]  out_total_frames_r;

  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_armed_r              <= armed_nxt;
      out_phase_r              <= run_phase_nxt;
      out_changed_bits_r       <= chg;
      out_status_change_note_r <= note_status;
      out_new_data_note_r      <= note_data;
      out_entered_run_r        <= entered;
      out_aborted_r            <= aborted;
      out_hold_count_r         <= hold_counter_nxt;
      out_total_frames_r       <= frame_total_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_armed              = out_armed_r;
  assign out_phase              = out_phase_r;
  assign out_changed_bits       = out_changed_bits_r;
  assign out_status_change_note = out_status_change_note_r;
  assign out_new_data_note      = out_new_data_note_r;
  assign out_entered_run        = out_entered_run_r;
  assign out_aborted            = out_aborted_r;
  assign out_hold_count         = out_hold_count_r;
  assign out_total_frames       = out_total_frames_r;

  // ---------------- assertions ----------------
  // start request always leaves the block armed
  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (s1_mode_r == MODE_START) |=> armed_r)
    else $error("start request did not arm the watchdog");

  // an abort result shows a disarmed, waiting block with a cleared counter
  a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_aborted_r |->
      !out_armed_r && !out_phase_r && (out_hold_count_r == '0))
    else $error("abort result with live state");

  // entering the run phase leaves the block running unless the same tick aborts
  a_enter_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_entered_run_r |->
      (out_phase_r && out_armed_r) || out_aborted_r)
    else $error("entered_run without running phase");

  // notes only come from the running phase
  a_notes_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_new_data_note_r || out_status_change_note_r) |->
      out_phase_r || out_aborted_r)
    else $error("note outside running phase");

  // empty output register never backs up the request side
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("request stalled with empty output register");

endmodule
